@@ hw/rtl/pps_pkg.sv @@
// Shared types, widths, codes and the arctangent table for the pure pursuit steering core.
// No dependencies.
package pps_pkg;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int CFG_W   = 21;
    localparam int CMD_W   = 2;
    localparam int OUTC_W  = 2;
    localparam int CIDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ODOM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [OUTC_W-1:0] OUT_DRIVE  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_NO_TGT = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_GOAL   = 2'd2;

    localparam logic [CIDX_W-1:0] REG_SPEED = 2'd0;
    localparam logic [CIDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MINLA = 2'd2;
    localparam logic [CIDX_W-1:0] REG_GOAL  = 2'd3;

    localparam logic [CFG_W-1:0] RST_SPEED = 21'd65536;
    localparam logic [CFG_W-1:0] RST_GAIN  = 21'd65536;
    localparam logic [CFG_W-1:0] RST_MINLA = 21'd26214;
    localparam logic [CFG_W-1:0] RST_GOAL  = 21'd6554;

    // CORDIC datapath
    localparam int CD_W = 36;
    localparam int CZ_W = 24;
    localparam logic signed [CZ_W-1:0] PI_Q16      = 24'sd205887;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = 24'sd102944;
    localparam logic signed [CD_W-1:0] K_Q24       = 36'sd10188014;

    localparam int HEAD_W  = 16;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 62;
    localparam int SUM_W   = 63;
    localparam int LOOK_W  = 25;
    localparam int LOOK2_W = 50;
    localparam int R2_W    = 42;
    localparam int SC_W    = 27;
    localparam int PROD_W  = 60;
    localparam int OFF_W   = 37;
    localparam int NUM_W   = 59;
    localparam int DIV_W   = 81;
    localparam int QUO_W   = 31;

    localparam logic [POS_W-1:0] ANG_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] ANG_NEG_SAT = 32'h8000_0000;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [CFG_W-1:0]        cfg_t;

    // atan(2^-i) in Q16.16 radians, rounded
    function automatic logic signed [CZ_W-1:0] atan_q16(input logic [4:0] i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            5'd0:    a = 24'sd51472;
            5'd1:    a = 24'sd30386;
            5'd2:    a = 24'sd16055;
            5'd3:    a = 24'sd8150;
            5'd4:    a = 24'sd4091;
            5'd5:    a = 24'sd2047;
            5'd6:    a = 24'sd1024;
            5'd7:    a = 24'sd512;
            5'd8:    a = 24'sd256;
            5'd9:    a = 24'sd128;
            5'd10:   a = 24'sd64;
            5'd11:   a = 24'sd32;
            5'd12:   a = 24'sd16;
            5'd13:   a = 24'sd8;
            5'd14:   a = 24'sd4;
            5'd15:   a = 24'sd2;
            5'd16:   a = 24'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/pps_if.sv @@
// Handshake channels of the pure pursuit steering core: input item, result item, config write.
// Depends on pps_pkg.
interface pps_item_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::CMD_W-1:0]     command;
    logic signed [pps_pkg::POS_W-1:0]  pos_x;
    logic signed [pps_pkg::POS_W-1:0]  pos_y;
    logic signed [pps_pkg::QUAT_W-1:0] quat_x;
    logic signed [pps_pkg::QUAT_W-1:0] quat_y;
    logic signed [pps_pkg::QUAT_W-1:0] quat_z;
    logic signed [pps_pkg::QUAT_W-1:0] quat_w;
    logic                          path_start;

    modport source (output valid, command, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    path_start, input ready);
    modport sink   (input valid, command, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    path_start, output ready);
endinterface

interface pps_result_if;
    logic                          valid;
    logic                          ready;
    logic signed [pps_pkg::POS_W-1:0] linear_rate;
    logic signed [pps_pkg::POS_W-1:0] angular_rate;
    logic [pps_pkg::OUTC_W-1:0]    outcome;
    logic                          last_result;

    modport source (output valid, linear_rate, angular_rate, outcome, last_result, input ready);
    modport sink   (input valid, linear_rate, angular_rate, outcome, last_result, output ready);
endinterface

interface pps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::CIDX_W-1:0]    index;
    logic [pps_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pure_pursuit_steering_core.sv @@
// Pure pursuit steering core: waypoint path memory, robot pose and a control tick engine.
// Depends on pps_pkg, pps_if, pps_ram, pps_cordic.
//
// A load item writes one waypoint into the path RAM in the cycle it is accepted. An odometry
// item stores the position and runs the CORDIC in vectoring mode for the yaw, unless both yaw
// terms are zero. A control tick computes the lookahead and streams waypoints out of the path
// RAM from the target index one per cycle through a 3-deep distance pipeline; if a target is
// found it reads the final waypoint for the goal test, runs the CORDIC in rotation mode for
// sine and cosine, forms the lateral offset and the steering numerator and divides by the
// squared lookahead one quotient bit per cycle, unless the quotient is zero or saturates. The
// scan through the single RAM read port dominates a tick on long paths. The block takes one
// item at a time; results sit in an output register, so the next item is accepted while the
// last result still waits to be taken.
// Config writes are always ready and take effect at once; write them only while idle.
module pure_pursuit_steering_core #(
    parameter int PATH_DEPTH   = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pps_item_if.sink     item,
    pps_result_if.source result,
    pps_cfg_if.sink      cfg
);
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);
    localparam int IDX_W = $clog2(PATH_DEPTH);
    localparam int PW    = pps_pkg::POS_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ODO     = 5'd1;
    localparam logic [4:0] S_ODO_WT  = 5'd2;
    localparam logic [4:0] S_PREP    = 5'd3;
    localparam logic [4:0] S_LOOK    = 5'd4;
    localparam logic [4:0] S_LOOK2   = 5'd5;
    localparam logic [4:0] S_SCAN    = 5'd6;
    localparam logic [4:0] S_GOAL_RD = 5'd7;
    localparam logic [4:0] S_GOAL_WT = 5'd8;
    localparam logic [4:0] S_SC_GO   = 5'd9;
    localparam logic [4:0] S_SC_WT   = 5'd10;
    localparam logic [4:0] S_OFF_MUL = 5'd11;
    localparam logic [4:0] S_OFF_SUB = 5'd12;
    localparam logic [4:0] S_NUM     = 5'd13;
    localparam logic [4:0] S_DIV_INI = 5'd14;
    localparam logic [4:0] S_DIV     = 5'd15;
    localparam logic [4:0] S_EMIT_NF = 5'd16;
    localparam logic [4:0] S_EMIT1   = 5'd17;
    localparam logic [4:0] S_EMIT2   = 5'd18;

    logic [4:0] state_reg, state_next;

    // configuration
    pps_pkg::cfg_t speed_reg, gain_reg, minla_reg, goal_reg;

    // path and pose state
    logic [CNT_W-1:0] count_reg;
    logic             path_valid_reg;
    logic [IDX_W-1:0] target_reg;
    pps_pkg::pos_t    robot_x_reg, robot_y_reg;
    logic signed [pps_pkg::HEAD_W-1:0] heading_reg;

    logic in_acc, cfg_acc, is_load, is_odom, is_tick, load_we, full;
    logic slot_free;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign in_acc     = item.valid && item.ready;
    assign cfg_acc    = cfg.valid && cfg.ready;
    assign is_load    = in_acc && (item.command == pps_pkg::CMD_LOAD);
    assign is_odom    = in_acc && (item.command == pps_pkg::CMD_ODOM);
    assign is_tick    = in_acc && (item.command == pps_pkg::CMD_TICK);
    assign full       = (count_reg >= CNT_W'(PATH_DEPTH));
    assign load_we    = is_load && (item.path_start || !full);

    // ---------------------------------------------------------------- path RAM
    logic [CNT_W-1:0] scan_idx_reg;
    logic             issue;
    logic [IDX_W-1:0] raddr, waddr, last_idx;
    logic [2*PW-1:0]  rdata;

    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign raddr    = (state_reg == S_GOAL_RD) ? last_idx : scan_idx_reg[IDX_W-1:0];
    assign waddr    = item.path_start ? '0 : count_reg[IDX_W-1:0];

    pps_ram #(.WIDTH(2 * PW), .DEPTH(PATH_DEPTH)) u_path (
        .clk   (clk),
        .we    (load_we),
        .waddr (waddr),
        .wdata ({item.pos_x, item.pos_y}),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ---------------------------------------------------------------- CORDIC
    logic signed [PW-1:0] sy_reg, cy_reg;
    logic cd_start, cd_vec, cd_done, vec_zero;
    logic signed [pps_pkg::CD_W-1:0] cd_x0, cd_y0, cd_x, cd_y, vx, vy;
    logic signed [pps_pkg::CZ_W-1:0] cd_z0, cd_z, vz0, rz, rz0;
    logic rneg;

    assign vx       = pps_pkg::CD_W'(cy_reg);
    assign vy       = pps_pkg::CD_W'(sy_reg);
    assign vec_zero = (cy_reg == '0) && (sy_reg == '0);
    assign vz0      = (vx >= 0) ? '0 : ((vy >= 0) ? pps_pkg::PI_Q16 : -pps_pkg::PI_Q16);

    assign rz   = pps_pkg::CZ_W'(heading_reg) <<< 3;
    assign rneg = (rz > pps_pkg::HALF_PI_Q16) || (rz < -pps_pkg::HALF_PI_Q16);
    assign rz0  = (rz > pps_pkg::HALF_PI_Q16) ? rz - pps_pkg::PI_Q16 :
                  (rz < -pps_pkg::HALF_PI_Q16) ? rz + pps_pkg::PI_Q16 : rz;

    assign cd_vec   = (state_reg == S_ODO);
    assign cd_start = (state_reg == S_ODO && !vec_zero) || (state_reg == S_SC_GO);
    assign cd_x0    = cd_vec ? ((vx < 0) ? -vx : vx) : pps_pkg::K_Q24;
    assign cd_y0    = cd_vec ? ((vx < 0) ? -vy : vy) : '0;
    assign cd_z0    = cd_vec ? vz0 : rz0;

    pps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cd_start),
        .vectoring (cd_vec),
        .x0        (cd_x0),
        .y0        (cd_y0),
        .z0        (cd_z0),
        .done      (cd_done),
        .x         (cd_x),
        .z         (cd_z),
        .y         (cd_y)
    );

    // yaw: round angle to Q3.13, clamp
    logic signed [pps_pkg::CZ_W-1:0] hz;
    logic signed [pps_pkg::HEAD_W-1:0] head_new;
    assign hz = (cd_z + pps_pkg::CZ_W'(4)) >>> 3;
    always_comb
    begin
        if (hz > pps_pkg::CZ_W'(32767))
            head_new = 16'sd32767;
        else if (hz < -pps_pkg::CZ_W'(32767))
            head_new = -16'sd32767;
        else
            head_new = hz[pps_pkg::HEAD_W-1:0];
    end

    // ---------------------------------------------------------------- distance pipeline
    // stage 1: RAM data; stage 2: differences; stage 3: squares, compare against the limit
    logic v1_reg, v2_reg, v3_reg, flush, hit, hit_take;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic signed [pps_pkg::DIFF_W-1:0] dx2_reg, dy2_reg, dx3_reg, dy3_reg, tdx_reg, tdy_reg;
    logic signed [pps_pkg::DIFF_W-1:0] dx1, dy1;
    logic [pps_pkg::DIFF_W-1:0] ax2, ay2;
    logic [pps_pkg::SQ_W-1:0] sqx3_reg, sqy3_reg;
    logic big3_reg;
    logic [pps_pkg::SUM_W-1:0] sum3, limit;
    logic [pps_pkg::LOOK_W-1:0]  look_reg;
    logic [pps_pkg::LOOK2_W-1:0] look2_reg;
    logic [pps_pkg::R2_W-1:0]    r2_reg;
    logic [2*pps_pkg::CFG_W-1:0] gs_reg;
    logic near_reg;

    assign dx1 = pps_pkg::DIFF_W'($signed(rdata[2*PW-1:PW])) - pps_pkg::DIFF_W'(robot_x_reg);
    assign dy1 = pps_pkg::DIFF_W'($signed(rdata[PW-1:0])) - pps_pkg::DIFF_W'(robot_y_reg);
    assign ax2 = dx2_reg[pps_pkg::DIFF_W-1] ? -dx2_reg : dx2_reg;
    assign ay2 = dy2_reg[pps_pkg::DIFF_W-1] ? -dy2_reg : dy2_reg;
    assign sum3  = pps_pkg::SUM_W'(sqx3_reg) + pps_pkg::SUM_W'(sqy3_reg);
    assign limit = (state_reg == S_SCAN) ? pps_pkg::SUM_W'(look2_reg)
                                         : pps_pkg::SUM_W'(r2_reg);
    assign hit      = big3_reg || (sum3 >= limit);
    assign hit_take = v3_reg && hit && (state_reg == S_SCAN);
    assign flush    = (state_reg == S_LOOK2) || hit_take;
    assign issue    = (state_reg == S_SCAN && scan_idx_reg < count_reg && !hit_take)
                   || (state_reg == S_GOAL_RD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg && !flush;
            v3_reg <= v2_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= raddr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx2_reg  <= dx1;
        dy2_reg  <= dy1;
        dx3_reg  <= dx2_reg;
        dy3_reg  <= dy2_reg;
        big3_reg <= ax2[pps_pkg::DIFF_W-1:PW-1] != '0 || ay2[pps_pkg::DIFF_W-1:PW-1] != '0;
        sqx3_reg <= ax2[PW-2:0] * ax2[PW-2:0];
        sqy3_reg <= ay2[PW-2:0] * ay2[PW-2:0];
    end

    // ---------------------------------------------------------------- steering arithmetic
    logic signed [pps_pkg::SC_W-1:0]   c_reg, s_reg;
    logic signed [pps_pkg::PROD_W-1:0] pc_reg, ps_reg;
    logic signed [pps_pkg::PROD_W:0]   pdiff;
    logic signed [pps_pkg::OFF_W-1:0]  off_reg;
    logic [pps_pkg::OFF_W-1:0]         mag_off;
    logic                              neg_reg;
    logic [pps_pkg::NUM_W-1:0]         num_reg;
    logic [pps_pkg::DIV_W-1:0]         rem_reg, dsh_reg, ovf_lim;
    logic [pps_pkg::QUO_W-1:0]         quo_reg;
    logic [4:0]                        bit_reg;
    logic [PW-1:0]                     ang_reg;

    assign pdiff   = (pps_pkg::PROD_W+1)'(pc_reg) - (pps_pkg::PROD_W+1)'(ps_reg);
    assign mag_off = off_reg[pps_pkg::OFF_W-1] ? -off_reg : off_reg;
    assign ovf_lim = pps_pkg::DIV_W'(look2_reg) << 15;

    always_ff @(posedge clk)
    begin
        if (is_odom)
        begin
            sy_reg <= (PW'($signed(item.quat_w)) * PW'($signed(item.quat_z))
                     + PW'($signed(item.quat_x)) * PW'($signed(item.quat_y))) <<< 1;
            cy_reg <= (PW'(1) <<< 28) - ((PW'($signed(item.quat_y)) * PW'($signed(item.quat_y))
                     + PW'($signed(item.quat_z)) * PW'($signed(item.quat_z))) <<< 1);
        end
        if (state_reg == S_PREP)
        begin
            gs_reg <= gain_reg * speed_reg;
            r2_reg <= goal_reg * goal_reg;
        end
        if (state_reg == S_LOOK)
            look_reg <= pps_pkg::LOOK_W'(gs_reg >> 16) + pps_pkg::LOOK_W'(minla_reg);
        if (state_reg == S_LOOK2)
            look2_reg <= look_reg * look_reg;
        if (hit_take)
        begin
            tdx_reg <= dx3_reg;
            tdy_reg <= dy3_reg;
        end
        if (state_reg == S_GOAL_WT && v3_reg)
            near_reg <= !hit;
        if (state_reg == S_SC_WT && cd_done)
        begin
            c_reg <= rneg ? -pps_pkg::SC_W'(cd_x) : pps_pkg::SC_W'(cd_x);
            s_reg <= rneg ? -pps_pkg::SC_W'(cd_y) : pps_pkg::SC_W'(cd_y);
        end
        if (state_reg == S_OFF_MUL)
        begin
            pc_reg <= pps_pkg::PROD_W'(c_reg) * pps_pkg::PROD_W'(tdy_reg);
            ps_reg <= pps_pkg::PROD_W'(s_reg) * pps_pkg::PROD_W'(tdx_reg);
        end
        if (state_reg == S_OFF_SUB)
            off_reg <= pps_pkg::OFF_W'(pdiff >>> 24);
        if (state_reg == S_NUM)
        begin
            num_reg <= pps_pkg::NUM_W'({speed_reg, 1'b0}) * pps_pkg::NUM_W'(mag_off);
            neg_reg <= off_reg[pps_pkg::OFF_W-1];
        end
        if (state_reg == S_DIV_INI)
        begin
            rem_reg <= pps_pkg::DIV_W'(num_reg) << 16;
            dsh_reg <= pps_pkg::DIV_W'(look2_reg) << (pps_pkg::QUO_W - 1);
            quo_reg <= '0;
            bit_reg <= '0;
            if (num_reg == '0)
                ang_reg <= '0;
            else if (pps_pkg::DIV_W'(num_reg) >= ovf_lim)
                ang_reg <= neg_reg ? pps_pkg::ANG_NEG_SAT : pps_pkg::ANG_POS_SAT;
        end
        if (state_reg == S_DIV)
        begin
            // restoring division, one quotient bit a cycle
            bit_reg <= bit_reg + 1'b1;
            dsh_reg <= dsh_reg >> 1;
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[pps_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[pps_pkg::QUO_W-2:0], 1'b0};
            end
        end
        else if (state_reg == S_EMIT1 && bit_reg == 5'(pps_pkg::QUO_W))
        begin
            // quotient just finished: apply sign once
            ang_reg <= neg_reg ? -PW'(quo_reg) : PW'(quo_reg);
            bit_reg <= '0;
        end
    end

    // ---------------------------------------------------------------- control FSM
    logic div_skip;
    assign div_skip  = (num_reg == '0) || (pps_pkg::DIV_W'(num_reg) >= ovf_lim);
    assign slot_free = !result.valid || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (is_odom)
                    state_next = S_ODO;
                else if (is_tick && path_valid_reg)
                    state_next = S_PREP;
            end
            S_ODO:     state_next = vec_zero ? S_IDLE : S_ODO_WT;
            S_ODO_WT:  state_next = cd_done ? S_IDLE : S_ODO_WT;
            S_PREP:    state_next = S_LOOK;
            S_LOOK:    state_next = S_LOOK2;
            S_LOOK2:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (hit_take)
                    state_next = S_GOAL_RD;
                else if (!v1_reg && !v2_reg && !v3_reg && scan_idx_reg >= count_reg)
                    state_next = S_EMIT_NF;
            end
            S_GOAL_RD: state_next = S_GOAL_WT;
            S_GOAL_WT: state_next = v3_reg ? S_SC_GO : S_GOAL_WT;
            S_SC_GO:   state_next = S_SC_WT;
            S_SC_WT:   state_next = cd_done ? S_OFF_MUL : S_SC_WT;
            S_OFF_MUL: state_next = S_OFF_SUB;
            S_OFF_SUB: state_next = S_NUM;
            S_NUM:     state_next = S_DIV_INI;
            S_DIV_INI: state_next = div_skip ? S_EMIT1 : S_DIV;
            S_DIV:     state_next = (bit_reg == 5'(pps_pkg::QUO_W - 1)) ? S_EMIT1 : S_DIV;
            S_EMIT_NF: state_next = slot_free ? S_IDLE : S_EMIT_NF;
            S_EMIT1:
            begin
                // after the divider the quotient is signed before the result is emitted
                if (bit_reg != 5'(pps_pkg::QUO_W) && slot_free)
                    state_next = near_reg ? S_EMIT2 : S_IDLE;
            end
            S_EMIT2:   state_next = slot_free ? S_IDLE : S_EMIT2;
            default:   state_next = S_IDLE;
        endcase
    end

    // result register
    logic out_load, out_valid_reg, out_last, out_drive;
    logic [pps_pkg::OUTC_W-1:0] out_code;
    logic signed [PW-1:0] lin_reg, angout_reg;
    logic [pps_pkg::OUTC_W-1:0] outc_reg;
    logic last_reg;

    assign out_load  = slot_free && ((state_reg == S_EMIT_NF) || (state_reg == S_EMIT2)
                     || (state_reg == S_EMIT1 && bit_reg != 5'(pps_pkg::QUO_W)));
    assign out_drive = (state_reg == S_EMIT1);
    assign out_code  = (state_reg == S_EMIT1) ? pps_pkg::OUT_DRIVE :
                       (state_reg == S_EMIT2) ? pps_pkg::OUT_GOAL : pps_pkg::OUT_NO_TGT;
    assign out_last  = (state_reg != S_EMIT1) || !near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            speed_reg      <= pps_pkg::RST_SPEED;
            gain_reg       <= pps_pkg::RST_GAIN;
            minla_reg      <= pps_pkg::RST_MINLA;
            goal_reg       <= pps_pkg::RST_GOAL;
            count_reg      <= '0;
            path_valid_reg <= 1'b0;
            target_reg     <= '0;
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            heading_reg    <= '0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (cfg_acc)
            begin
                unique case (cfg.index)
                    pps_pkg::REG_SPEED: speed_reg <= cfg.data;
                    pps_pkg::REG_GAIN:  gain_reg  <= cfg.data;
                    pps_pkg::REG_MINLA: minla_reg <= cfg.data;
                    pps_pkg::REG_GOAL:  goal_reg  <= cfg.data;
                    default: ;
                endcase
            end

            if (is_load)
            begin
                path_valid_reg <= 1'b1;
                if (item.path_start)
                begin
                    count_reg  <= CNT_W'(1);
                    target_reg <= '0;
                end
                else if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (is_odom)
            begin
                robot_x_reg <= item.pos_x;
                robot_y_reg <= item.pos_y;
            end
            if (state_reg == S_ODO && vec_zero)
                heading_reg <= '0;
            if (state_reg == S_ODO_WT && cd_done)
                heading_reg <= head_new;

            if (state_reg == S_LOOK2)
                scan_idx_reg <= CNT_W'(target_reg);
            else if (issue && state_reg == S_SCAN)
                scan_idx_reg <= scan_idx_reg + 1'b1;

            if (hit_take)
                target_reg <= idx3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            lin_reg    <= out_drive ? PW'(speed_reg) : '0;
            angout_reg <= out_drive ? ang_reg : '0;
            outc_reg   <= out_code;
            last_reg   <= out_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.linear_rate  = lin_reg;
    assign result.angular_rate = angout_reg;
    assign result.outcome      = outc_reg;
    assign result.last_result  = last_reg;
endmodule

@@ hw/rtl/pps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/pps_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on pps_pkg (widths, arctangent table).
module pps_cordic #(
    parameter int STEPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               vectoring,
    input  logic signed [pps_pkg::CD_W-1:0]    x0,
    input  logic signed [pps_pkg::CD_W-1:0]    y0,
    input  logic signed [pps_pkg::CZ_W-1:0]    z0,
    output logic                               done,
    output logic signed [pps_pkg::CD_W-1:0]    x,
    output logic signed [pps_pkg::CZ_W-1:0]    z,
    output logic signed [pps_pkg::CD_W-1:0]    y
);
    localparam int SW = $clog2(STEPS + 1);

    logic signed [pps_pkg::CD_W-1:0] x_reg, y_reg, xs, ys;
    logic signed [pps_pkg::CZ_W-1:0] z_reg, a;
    logic [SW-1:0] step_reg;
    logic busy_reg, done_reg, mode_reg, down;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign a  = pps_pkg::atan_q16(5'(step_reg));
    // down: x -= y>>i, y += x>>i, z -= atan
    assign down = mode_reg ? (y_reg <= 0) : (z_reg >= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == SW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
            mode_reg <= vectoring;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (down)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a;
            end
        end
    end

    assign done = done_reg;
    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;
endmodule

@@ bench/tb_top.sv @@
// Testbench of pure_pursuit_steering_core: a queued driver, a result monitor and a predictor
// of the path tracking arithmetic. Depends on pps_pkg and the channel interfaces in pps_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pps_pkg::*;

    typedef struct {
        logic [CMD_W-1:0] command;
        pos_t             pos_x;
        pos_t             pos_y;
        logic signed [QUAT_W-1:0] quat_x, quat_y, quat_z, quat_w;
        logic             path_start;
    } steer_item_t;

    typedef struct {
        logic [POS_W-1:0]  linear_rate;
        logic [POS_W-1:0]  angular_rate;
        logic [OUTC_W-1:0] outcome;
        logic              last_result;
    } steer_cmd_t;

    localparam int DEPTH       = 256;
    localparam int STEPS       = 16;
    localparam int SETTLE      = 500;      // longest tick on a full path plus margin
    localparam int CYCLE_LIMIT = 3000000;
    localparam longint PI_RAD      = 205887;
    localparam longint HALF_PI_RAD = 102944;
    localparam longint GAIN_COMP   = 10188014;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pps_item_if   item_ch();
    pps_result_if res_ch();
    pps_cfg_if    cfg_ch();

    pure_pursuit_steering_core #(.PATH_DEPTH(DEPTH), .CORDIC_STEPS(STEPS)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch.sink),
        .result(res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: path, pose and the four registers
    // ---------------------------------------------------------------
    longint     path_x [DEPTH];
    longint     path_y [DEPTH];
    int         path_len;
    bit         have_path;
    int         aim_idx;
    longint     pose_x, pose_y, pose_heading;
    longint     speed_reg, gain_reg, minla_reg, goal_reg;

    steer_cmd_t  pending_cmds[$];   // expected results, oldest first
    steer_item_t stim_q[$];         // items waiting for the driver
    int          fail_count = 0;
    bit          no_idle = 1'b0;    // phases that run the channels flat out

    // atan(2^-i) in Q16.16, rounded; entries past 16 are zero
    function automatic longint atan_step(int i);
        longint t [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                           64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    // vectoring CORDIC, angle rounded to Q3.13 and clamped
    function automatic longint yaw_of(longint vx, longint vy);
        longint ang, hd, sx, sy;
        ang = 0;
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        if (vx < 0)
        begin
            ang = (vy >= 0) ? PI_RAD : -PI_RAD;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0)
            begin
                vx += sy; vy -= sx; ang += atan_step(i);
            end
            else
            begin
                vx -= sy; vy += sx; ang -= atan_step(i);
            end
        end
        hd = (ang + 4) >>> 3;
        if (hd > 32767) hd = 32767;
        if (hd < -32767) hd = -32767;
        return hd;
    endfunction

    // rotation CORDIC for sine and cosine in Q.24
    task automatic heading_trig(input longint hd, output longint sn, output longint cs);
        longint z, x, y, xs, ys;
        bit flip;
        z = hd * 8; x = GAIN_COMP; y = 0; flip = 1'b0;
        if (z > HALF_PI_RAD)
        begin
            z -= PI_RAD; flip = 1'b1;
        end
        else if (z < -HALF_PI_RAD)
        begin
            z += PI_RAD; flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    function automatic bit reaches(longint dx, longint dy, longint lim);
        logic [63:0] ax, ay, l;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        l  = lim;
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
        begin
            return 1'b1;
        end
        return (ax * ax + ay * ay) >= l * l;
    endfunction

    // speed*2*offset/L^2 in Q16.16, truncated, saturated
    function automatic logic [POS_W-1:0] turn_rate(longint spd, longint off, longint look);
        logic [63:0] num, den, q, r, mag;
        num = 64'd2 * spd * ((off < 0) ? -off : off);
        den = look * look;
        if (num == 0)
        begin
            return '0;
        end
        if (den == 0)
        begin
            return (off < 0) ? ANG_NEG_SAT : ANG_POS_SAT;
        end
        q = num / den;
        if (q >= 64'h8000)
        begin
            return (off < 0) ? ANG_NEG_SAT : ANG_POS_SAT;
        end
        r = num % den;
        mag = q << 16;
        for (int b = 0; b < 16; b++)
        begin
            r = r << 1;
            if (r >= den)
            begin
                r -= den;
                mag[15-b] = 1'b1;
            end
        end
        return (off < 0) ? -mag[31:0] : mag[31:0];
    endfunction

    function automatic steer_cmd_t make_cmd(longint lin, logic [POS_W-1:0] ang,
                                            logic [OUTC_W-1:0] oc, logic last);
        steer_cmd_t c;
        c.linear_rate = lin; c.angular_rate = ang; c.outcome = oc; c.last_result = last;
        return c;
    endfunction

    // advance the predicted state by one accepted item and queue its results
    task automatic track_item(input steer_item_t it);
        longint look, dx, dy, sn, cs, off, gx, gy, qx, qy, qz, qw;
        logic [POS_W-1:0] ang;
        bit found;
        dx = 0; dy = 0; found = 1'b0;
        case (it.command)
            CMD_LOAD:
            begin
                if (it.path_start)
                begin
                    path_len = 0; aim_idx = 0;
                end
                have_path = 1'b1;
                if (path_len < DEPTH)
                begin
                    path_x[path_len] = it.pos_x;
                    path_y[path_len] = it.pos_y;
                    path_len++;
                end
            end
            CMD_ODOM:
            begin
                qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
                pose_x = it.pos_x;
                pose_y = it.pos_y;
                pose_heading = yaw_of((64'sd1 <<< 28) - 2 * (qy * qy + qz * qz),
                                      2 * (qw * qz + qx * qy));
            end
            CMD_TICK:
            begin
                if (have_path)
                begin
                    look = ((gain_reg * speed_reg) >>> 16) + minla_reg;
                    for (int i = aim_idx; i < path_len; i++)
                    begin
                        dx = path_x[i] - pose_x;
                        dy = path_y[i] - pose_y;
                        if (reaches(dx, dy, look))
                        begin
                            aim_idx = i;
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found)
                    begin
                        pending_cmds.push_back(make_cmd(0, '0, OUT_NO_TGT, 1'b1));
                    end
                    else
                    begin
                        heading_trig(pose_heading, sn, cs);
                        off = (cs * dy - sn * dx) >>> 24;
                        ang = turn_rate(speed_reg, off, look);
                        gx = path_x[path_len-1] - pose_x;
                        gy = path_y[path_len-1] - pose_y;
                        if (!reaches(gx, gy, goal_reg))
                        begin
                            pending_cmds.push_back(make_cmd(speed_reg, ang, OUT_DRIVE, 1'b0));
                            pending_cmds.push_back(make_cmd(0, '0, OUT_GOAL, 1'b1));
                        end
                        else
                        begin
                            pending_cmds.push_back(make_cmd(speed_reg, ang, OUT_DRIVE, 1'b1));
                        end
                    end
                end
            end
            default: ;  // command 3 does nothing
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driver: items change on the falling edge
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    steer_item_t cur_item;
    bit          item_taken = 1'b0;
    int          send_gap = 0;

    always @(posedge clk)
    begin
        item_taken <= item_ch.valid && item_ch.ready;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            track_item(cur_item);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!item_ch.valid || item_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                item_ch.valid <= 1'b0;
            end
            else if (stim_q.size() > 0)
            begin
                cur_item = stim_q.pop_front();
                item_ch.command    <= cur_item.command;
                item_ch.pos_x      <= cur_item.pos_x;
                item_ch.pos_y      <= cur_item.pos_y;
                item_ch.quat_x     <= cur_item.quat_x;
                item_ch.quat_y     <= cur_item.quat_y;
                item_ch.quat_z     <= cur_item.quat_z;
                item_ch.quat_w     <= cur_item.quat_w;
                item_ch.path_start <= cur_item.path_start;
                item_ch.valid      <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results sampled on the rising edge, ready toggled on the falling edge
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        steer_cmd_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with nothing expected: lin %h ang %h outcome %0d last %0b",
                         $time, res_ch.linear_rate, res_ch.angular_rate, res_ch.outcome,
                         res_ch.last_result);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (res_ch.linear_rate !== want.linear_rate)
                begin
                    fail_count++;
                    $display("%0t: linear_rate expected %h actual %h", $time,
                             want.linear_rate, res_ch.linear_rate);
                end
                if (res_ch.angular_rate !== want.angular_rate)
                begin
                    fail_count++;
                    $display("%0t: angular_rate expected %h actual %h", $time,
                             want.angular_rate, res_ch.angular_rate);
                end
                if (res_ch.outcome !== want.outcome)
                begin
                    fail_count++;
                    $display("%0t: outcome expected %0d actual %0d", $time,
                             want.outcome, res_ch.outcome);
                end
                if (res_ch.last_result !== want.last_result)
                begin
                    fail_count++;
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want.last_result, res_ch.last_result);
                end
            end
        end
    end

    // watchdog
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic steer_item_t mk(logic [CMD_W-1:0] c, longint x, longint y, bit st = 0);
        steer_item_t it;
        it.command = c; it.pos_x = x; it.pos_y = y; it.path_start = st;
        it.quat_x = 0; it.quat_y = 0; it.quat_z = 0; it.quat_w = 16'sd16384;
        return it;
    endfunction

    function automatic steer_item_t mk_odom(longint x, longint y, int qx, int qy, int qz, int qw);
        steer_item_t it;
        it = mk(CMD_ODOM, x, y);
        it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
        return it;
    endfunction

    function automatic int rquat();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16384;
        if (r == 1) return -16384;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // small offsets in Q16.16, now and then the full 32-bit range
    function automatic longint rcoord(longint base, int spread);
        if ($urandom_range(0, 29) == 0)
        begin
            return longint'(signed'(32'($urandom())));
        end
        return base + longint'(int'($urandom_range(0, 2 * spread))) - spread;
    endfunction

    task automatic wait_drained();
        while (stim_q.size() > 0 || item_ch.valid || pending_cmds.size() > 0)
        begin
            @(posedge clk);
        end
        // ticks with no result may still be running
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_SPEED: speed_reg = val;
            REG_GAIN:  gain_reg  = val;
            REG_MINLA: minla_reg = val;
            default:   goal_reg  = val;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic longint rcfg();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1048576;
        if (r < 5) return $urandom_range(0, 1048576);
        return $urandom_range(0, 131072);
    endfunction

    // well-formed path/pose/tick sequences with some noise mixed in
    task automatic queue_random(int budget);
        int n, k;
        longint bx, by, rx, ry;
        steer_item_t it;
        while (budget > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                it = mk_odom(longint'(signed'(32'($urandom()))), longint'(signed'(32'($urandom()))),
                             rquat(), rquat(), rquat(), rquat());
                it.command = $urandom_range(0, 3);
                it.path_start = $urandom_range(0, 1);
                stim_q.push_back(it);
                budget--;
            end
            else
            begin
                bx = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                by = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    stim_q.push_back(mk(CMD_LOAD, rcoord(bx + i * 40000, 30000),
                                        rcoord(by, 60000), i == 0 && $urandom_range(0, 7) != 0));
                end
                k = $urandom_range(1, 6);
                for (int j = 0; j < k; j++)
                begin
                    rx = rcoord(bx + j * 50000, 80000);
                    ry = rcoord(by, 80000);
                    stim_q.push_back(mk_odom(rx, ry, rquat(), rquat(), rquat(), rquat()));
                    stim_q.push_back(mk(CMD_TICK, $urandom(), $urandom()));
                end
                budget -= n + 2 * k;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        item_ch.valid = 1'b0; item_ch.command = CMD_LOAD; item_ch.pos_x = '0;
        item_ch.pos_y = '0; item_ch.quat_x = '0; item_ch.quat_y = '0;
        item_ch.quat_z = '0; item_ch.quat_w = '0; item_ch.path_start = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_SPEED; cfg_ch.data = '0;
        path_len = 0; have_path = 1'b0; aim_idx = 0;
        pose_x = 0; pose_y = 0; pose_heading = 0;
        speed_reg = RST_SPEED; gain_reg = RST_GAIN; minla_reg = RST_MINLA; goal_reg = RST_GOAL;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults give L = 1.4 m, goal 0.1 m
        stim_q.push_back(mk(CMD_TICK, 0, 0));                 // tick before any path
        stim_q.push_back(mk(2'd3, -1, -1, 1));                // unused command code
        stim_q.push_back(mk_odom(0, 0, -5000, 8192, 8192, 5000));  // yaw terms both zero
        stim_q.push_back(mk_odom(32'sh7FFF_FFFF, 32'sh8000_0000,
                                 16384, -16384, 16384, -16384));
        stim_q.push_back(mk_odom(0, 0, 0, 0, 0, 16384));      // heading zero at origin
        stim_q.push_back(mk(CMD_LOAD, 0, 0, 0));              // first load without start
        stim_q.push_back(mk(CMD_LOAD, 65536, 0, 0));
        stim_q.push_back(mk(CMD_LOAD, 131072, 32768, 0));
        stim_q.push_back(mk(CMD_LOAD, 196608, -65536, 0));
        stim_q.push_back(mk(CMD_TICK, 0, 0));                 // drive toward third point
        stim_q.push_back(mk_odom(131072, -32768, 0, 0, 11585, 11585));
        stim_q.push_back(mk(CMD_TICK, 0, 0));                 // no point left beyond the lookahead
        stim_q.push_back(mk(CMD_LOAD, 10000, 10000, 1));      // short path, nothing far enough
        stim_q.push_back(mk(CMD_LOAD, -10000, 5000, 0));
        stim_q.push_back(mk_odom(0, 0, 0, 0, -16384, 0));
        stim_q.push_back(mk(CMD_TICK, 0, 0));
        stim_q.push_back(mk(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, 1));  // far extremes
        stim_q.push_back(mk(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
        stim_q.push_back(mk_odom(-65536, 65536, 16384, 0, 0, 0));
        stim_q.push_back(mk(CMD_TICK, 0, 0));
        wait_drained();

        // full path: the loads past the depth are dropped
        no_idle = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
        begin
            stim_q.push_back(mk(CMD_LOAD, i * 8192, (i % 7) * 4096, i == 0));
        end
        stim_q.push_back(mk_odom(0, 0, 0, 0, 0, 16384));
        stim_q.push_back(mk(CMD_TICK, 0, 0));
        stim_q.push_back(mk_odom((DEPTH - 1) * 8192, 0, 0, 0, 0, 16384));
        stim_q.push_back(mk(CMD_TICK, 0, 0));
        wait_drained();
        no_idle = 1'b0;

        // zero lookahead with a large speed drives the turn rate into saturation
        write_reg(REG_GAIN, 0);
        write_reg(REG_MINLA, 0);
        write_reg(REG_SPEED, 1048576);
        write_reg(REG_GOAL, 0);
        queue_random(60);
        wait_drained();

        write_reg(REG_SPEED, RST_SPEED);
        write_reg(REG_GAIN, RST_GAIN);
        write_reg(REG_MINLA, RST_MINLA);
        write_reg(REG_GOAL, RST_GOAL);
        queue_random(110);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_SPEED, rcfg());
            write_reg(REG_GAIN, rcfg());
            write_reg(REG_MINLA, rcfg());
            write_reg(REG_GOAL, (p == 3) ? 1048576 : rcfg());
            no_idle = (p == 1);
            queue_random(70);
            wait_drained();
        end

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
